@@ design/utf8v_pkg.sv @@
// Shared types and constants for the UTF-8 text validator.
package utf8v_pkg;

  // Codepoint counter width; the count register is one bit wider.
  localparam int unsigned CountWidth = 16;

  // Configuration port.
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = 16;
  localparam logic [CfgIdxWidth-1:0] CfgMaxCodepoints = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgAllowEmpty    = 1'd1;
  localparam logic [CfgDataWidth-1:0] MaxCodepointsRst = 16'd255;
  localparam logic AllowEmptyRst = 1'b0;

  // Byte classes.
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Val  = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Val  = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Val  = 8'hf0;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContVal   = 8'h80;
  localparam logic [7:0] AsciiTop  = 8'h80;

  // Codepoint limits.
  localparam logic [20:0] CpMax      = 21'h10ffff;
  localparam logic [20:0] CpSurLo    = 21'h00d800;
  localparam logic [20:0] CpSurHi    = 21'h00dfff;
  localparam logic [20:0] CpMin2     = 21'h000080;
  localparam logic [20:0] CpMin3     = 21'h000800;
  localparam logic [20:0] CpMin4     = 21'h010000;
  localparam logic [20:0] CpCtrlTop  = 21'h000020;
  localparam logic [20:0] CpDel      = 21'h00007f;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
    logic       empty_text;
  } item_t;

  typedef struct packed {
    logic [1:0]            bytes_rem;
    logic [2:0]            seq_len;
    logic [20:0]           partial_cp;
    logic [CountWidth:0]   cp_total;
    logic                  error_seen;
  } scan_state_t;

  typedef struct packed {
    logic has_result;
    logic text_valid;
  } verdict_t;

endpackage

@@ design/utf8v_if.sv @@
// Handshake channels: input byte items and verdict items.
interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;
  logic       empty_text;

  modport source (output valid, output text_byte, output last_byte, output empty_text,
                  input ready);
  modport sink (input valid, input text_byte, input last_byte, input empty_text,
                output ready);
endinterface

interface utf8v_out_if;
  logic valid;
  logic ready;
  logic text_valid;

  modport source (output valid, output text_valid, input ready);
  modport sink (input valid, input text_valid, output ready);
endinterface

@@ design/utf8_text_validator_top.sv @@
// Top level of the UTF-8 text validator.
//
//  channel    | dir | handshake      | payload
//  -----------+-----+----------------+------------------------------------
//  item_i     | in  | valid / ready  | text_byte[7:0], last_byte, empty_text
//  verdict_o  | out | valid / ready  | text_valid
//  cfg_*      | in  | cfg_we_i only  | cfg_idx_i, cfg_data_i[15:0]
//
//  One item a cycle while item_i does not stall. An accepted item is held
//  in the input register, then the step logic updates the scan state and,
//  on a last byte or an empty text, loads the verdict register, which
//  drives verdict_o. item_i stalls only when an item waits to load the
//  verdict register while a verdict is still held there. rst_ni clears the
//  scan state, both valid flags and restores the register reset values.
module utf8_text_validator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  utf8v_in_if.sink                            item_i,
  utf8v_out_if.source                         verdict_o,
  input  logic                                cfg_we_i,
  input  logic [utf8v_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [utf8v_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import utf8v_pkg::*;

  // input register
  logic        in_valid_q;
  item_t       in_item_q;

  // scan state, verdict register, configuration
  scan_state_t state_q, state_d;
  verdict_t    step_verdict;
  logic        out_valid_q, out_valid_d;
  logic        out_text_valid_q, out_text_valid_d;
  logic [CfgDataWidth-1:0] max_cp_q;
  logic        allow_empty_q;
  logic        consume;
  logic        in_ready;

  utf8v_step u_step (
    .state_i       (state_q),
    .item_i        (in_item_q),
    .limit_i       (CountWidth'(max_cp_q)),
    .allow_empty_i (allow_empty_q),
    .state_o       (state_d),
    .verdict_o     (step_verdict)
  );

  // Held item moves on unless it carries a verdict and the verdict register is busy.
  assign consume  = in_valid_q &&
                    (!step_verdict.has_result || !out_valid_q || verdict_o.ready);
  assign in_ready = !in_valid_q || consume;

  assign item_i.ready         = in_ready;
  assign verdict_o.valid      = out_valid_q;
  assign verdict_o.text_valid = out_text_valid_q;

  always_comb begin
    out_valid_d      = out_valid_q;
    out_text_valid_d = out_text_valid_q;
    if (consume && step_verdict.has_result) begin
      out_valid_d      = 1'b1;
      out_text_valid_d = step_verdict.text_valid;
    end else if (verdict_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= '0;
      max_cp_q      <= MaxCodepointsRst;
      allow_empty_q <= AllowEmptyRst;
    end else begin
      if (in_ready) begin
        in_valid_q <= item_i.valid;
      end
      out_valid_q <= out_valid_d;
      if (consume) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMaxCodepoints: max_cp_q      <= cfg_data_i;
          CfgAllowEmpty:    allow_empty_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready && item_i.valid) begin
      in_item_q.text_byte  <= item_i.text_byte;
      in_item_q.last_byte  <= item_i.last_byte;
      in_item_q.empty_text <= item_i.empty_text;
    end
    out_text_valid_q <= out_text_valid_d;
  end

endmodule

@@ design/utf8v_step.sv @@
// Next-state and verdict logic for one byte item.
module utf8v_step (
  input  utf8v_pkg::scan_state_t          state_i,
  input  utf8v_pkg::item_t                item_i,
  input  logic [utf8v_pkg::CountWidth-1:0] limit_i,
  input  logic                            allow_empty_i,
  output utf8v_pkg::scan_state_t          state_o,
  output utf8v_pkg::verdict_t             verdict_o
);
  import utf8v_pkg::*;

  scan_state_t           nxt;
  logic [7:0]            b;
  logic                  take_cp;
  logic [20:0]           cp;
  logic [2:0]            cp_len;
  logic [20:0]           shifted;
  logic                  bad_cp;
  logic [CountWidth:0]   lim_ext;
  logic [CountWidth:0]   total_inc;

  assign b       = item_i.text_byte;
  assign lim_ext = {1'b0, limit_i};
  assign shifted = {state_i.partial_cp[14:0], b[5:0]};

  always_comb begin
    nxt       = state_i;
    take_cp   = 1'b0;
    cp        = '0;
    cp_len    = '0;
    bad_cp    = 1'b0;
    total_inc = state_i.cp_total;

    if (!state_i.error_seen) begin
      if (state_i.bytes_rem == 2'd0) begin
        if (b < AsciiTop) begin
          take_cp = 1'b1;
          cp      = {13'd0, b};
          cp_len  = 3'd1;
        end else if ((b & Lead2Mask) == Lead2Val) begin
          nxt.partial_cp = {16'd0, b[4:0]};
          nxt.seq_len    = 3'd2;
          nxt.bytes_rem  = 2'd1;
        end else if ((b & Lead3Mask) == Lead3Val) begin
          nxt.partial_cp = {17'd0, b[3:0]};
          nxt.seq_len    = 3'd3;
          nxt.bytes_rem  = 2'd2;
        end else if ((b & Lead4Mask) == Lead4Val) begin
          nxt.partial_cp = {18'd0, b[2:0]};
          nxt.seq_len    = 3'd4;
          nxt.bytes_rem  = 2'd3;
        end else begin
          nxt.error_seen = 1'b1;
        end
      end else if ((b & ContMask) != ContVal) begin
        nxt.error_seen = 1'b1;
      end else begin
        nxt.partial_cp = shifted;
        nxt.bytes_rem  = state_i.bytes_rem - 2'd1;
        if (state_i.bytes_rem == 2'd1) begin
          take_cp        = 1'b1;
          cp             = shifted;
          cp_len         = state_i.seq_len;
          nxt.partial_cp = '0;
          nxt.seq_len    = '0;
        end
      end

      if (take_cp) begin
        bad_cp = (cp_len == 3'd2 && cp < CpMin2) || (cp_len == 3'd3 && cp < CpMin3) ||
                 (cp_len == 3'd4 && cp < CpMin4) || (cp > CpMax) ||
                 (cp >= CpSurLo && cp <= CpSurHi) || (cp < CpCtrlTop) || (cp == CpDel);
        if (bad_cp) begin
          nxt.error_seen = 1'b1;
        end else begin
          // count saturates one above the limit
          if (state_i.cp_total <= lim_ext) begin
            total_inc = state_i.cp_total + (CountWidth+1)'(1);
          end
          nxt.cp_total = total_inc;
          if (total_inc > lim_ext) begin
            nxt.error_seen = 1'b1;
          end
        end
      end
    end

    verdict_o = '0;
    state_o   = nxt;
    if (item_i.empty_text) begin
      verdict_o.has_result = 1'b1;
      verdict_o.text_valid = allow_empty_i;
      state_o              = '0;
    end else if (item_i.last_byte) begin
      verdict_o.has_result = 1'b1;
      verdict_o.text_valid = !(nxt.error_seen || (nxt.bytes_rem != 2'd0));
      state_o              = '0;
    end
  end

endmodule

@@ design/utf8v_checker.sv @@
// Port-level checks for the validator top, attached by bind.
module utf8v_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_text_valid_i
);

  // no verdict shows while reset is held
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("verdict valid during reset");

  // input only stalls behind a stalled verdict
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a blocked verdict");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("verdict dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_text_valid_i))
    else $error("verdict changed while stalled");

endmodule

bind utf8_text_validator_top utf8v_checker u_utf8v_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (item_i.valid),
  .in_ready_i       (item_i.ready),
  .out_valid_i      (verdict_o.valid),
  .out_ready_i      (verdict_o.ready),
  .out_text_valid_i (verdict_o.text_valid)
);
